// ===== rtl/core/amt_pkg.sv =====
// Shared types, widths and constants for the adaptive mean threshold block.
// Used by amt_front, amt_back and adaptive_mean_threshold; depends on nothing else.
`timescale 1ns / 1ps

package amt_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int MAX_WINDOW = 31;
  localparam int BURST      = 16;

  localparam int PIX_W     = 8;
  localparam int COL_W     = 11;
  localparam int ROW_W     = 11;
  localparam int DIM_W     = 12;
  localparam int WIN_W     = 5;
  localparam int RAD_W     = 4;
  localparam int DIV_W     = 10;
  localparam int SUM_W     = 18;
  localparam int PROD_W    = 20;
  localparam int CNT_W     = 5;
  localparam int RING_BITS = 5;
  localparam int RING_ROWS = 1 << RING_BITS;
  localparam int ADDR_W    = RING_BITS + COL_W;
  localparam int RAM_DEPTH = RING_ROWS * MAX_WIDTH;
  localparam int POS_W     = 13;
  localparam int CFG_W     = 12;
  localparam int IDX_W     = 2;
  localparam int TDATA_W   = 32;

  localparam logic [PIX_W-1:0] VALUE_SET   = 8'd255;
  localparam logic [PIX_W-1:0] VALUE_CLEAR = 8'd0;

  typedef enum logic [IDX_W-1:0] {
    REG_WIDTH     = 2'd0,
    REG_HEIGHT    = 2'd1,
    REG_WINDOW    = 2'd2,
    REG_THRESHOLD = 2'd3
  } reg_idx_t;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SUM,
    ST_WAIT,
    ST_MUL,
    ST_CMP
  } state_t;

  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] pixel;
  } item_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [WIN_W-1:0] window;
    logic [PIX_W-1:0] threshold;
  } cfg_t;

  // Zero maps to one, values above the limit saturate to it.
  function automatic logic [DIM_W-1:0] fit_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

// ===== rtl/core/amt_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Used for the raw line ring; depends on nothing else.
`timescale 1ns / 1ps

module amt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read ports work independently.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/amt_front.sv =====
// Front end: takes input requests and holds them in a two-entry queue.
// Depends on amt_pkg.
`timescale 1ns / 1ps

module amt_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  amt_pkg::item_t  in_item,
  output logic            item_valid,
  output amt_pkg::item_t  item,
  input  logic            item_pop
);

  amt_pkg::item_t slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       push;

  assign in_ready   = (count != 2'd2);
  assign push       = in_valid && in_ready;
  assign item_valid = (count != 2'd0);
  assign item       = slots[rp];

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= in_item;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (item_pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(item_pop);
    end
  end

endmodule

// ===== rtl/core/amt_back.sv =====
// Back end: frame bookkeeping, raw line ring, window sum sequencer and output register.
// Depends on amt_pkg and amt_ram.
`timescale 1ns / 1ps

module amt_back (
  input  logic                         clk,
  input  logic                         rst,
  input  amt_pkg::cfg_t                cfg,
  input  logic                         item_valid,
  input  amt_pkg::item_t               item,
  output logic                         item_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [amt_pkg::PIX_W-1:0]    out_value,
  output logic [amt_pkg::COL_W-1:0]    out_col,
  output logic [amt_pkg::ROW_W-1:0]    out_row,
  output logic                         out_run_last,
  output logic                         out_frame_last
);

  amt_pkg::state_t state, state_next;

  logic [amt_pkg::DIM_W-1:0] act_w, act_h;
  logic [amt_pkg::RAD_W-1:0] act_r;
  logic [amt_pkg::DIV_W-1:0] act_div;
  logic [amt_pkg::PIX_W-1:0] act_thr;

  logic [amt_pkg::COL_W-1:0] in_col, have_col, out_col_count;
  logic [amt_pkg::ROW_W-1:0] in_row, have_row, out_row_count;
  logic                      busy, frame_full;
  logic [amt_pkg::CNT_W-1:0] n;

  logic signed [amt_pkg::POS_W-1:0] ry, cx;
  logic [amt_pkg::SUM_W-1:0]  acc;
  logic [amt_pkg::PIX_W-1:0]  centre;
  logic [amt_pkg::PROD_W-1:0] prod;
  logic                       rd_sum_q, rd_ctr_q;

  logic                      hold_valid, hold_flast;
  logic [amt_pkg::PIX_W-1:0] hold_value;
  logic [amt_pkg::COL_W-1:0] hold_col;
  logic [amt_pkg::ROW_W-1:0] hold_row;

  logic                       ram_we, ram_re;
  logic [amt_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [amt_pkg::PIX_W-1:0]  ram_rdata;

  logic [amt_pkg::DIM_W-1:0] ny, nx, ny_c, nx_c;
  logic ready_pos, cond, out_free, send_hold, start, last_issue, pos_last;
  logic signed [amt_pkg::POS_W-1:0] x_lo, x_hi, y_lo, y_hi, w_max, h_max;
  logic [amt_pkg::COL_W-1:0] col_c;
  logic [amt_pkg::ROW_W-1:0] row_c;
  logic frame_start;
  logic [amt_pkg::DIM_W-1:0] w_eff, h_eff, w_new, h_new;
  logic [amt_pkg::WIN_W-1:0] win_new;

  // Readiness of the next result position against what has arrived.
  always_comb begin
    ny   = {1'b0, out_row_count} + amt_pkg::DIM_W'(act_r);
    nx   = {1'b0, out_col_count} + amt_pkg::DIM_W'(act_r);
    ny_c = (ny > act_h - 1'b1) ? act_h - 1'b1 : ny;
    nx_c = (nx > act_w - 1'b1) ? act_w - 1'b1 : nx;
    ready_pos = frame_full || (ny_c < {1'b0, have_row}) ||
                ((ny_c == {1'b0, have_row}) && (nx_c <= {1'b0, have_col}));
    cond      = (n < amt_pkg::CNT_W'(amt_pkg::BURST)) && busy && ready_pos;
    out_free  = !out_valid || out_ready;
    pos_last  = ({1'b0, out_col_count} == act_w - 1'b1) &&
                ({1'b0, out_row_count} == act_h - 1'b1);
  end

  // Window bounds and clamped read position.
  always_comb begin
    x_lo  = $signed({2'b00, out_col_count}) - $signed({9'd0, act_r});
    x_hi  = $signed({2'b00, out_col_count}) + $signed({9'd0, act_r});
    y_lo  = $signed({2'b00, out_row_count}) - $signed({9'd0, act_r});
    y_hi  = $signed({2'b00, out_row_count}) + $signed({9'd0, act_r});
    w_max = $signed({1'b0, act_w - 1'b1});
    h_max = $signed({1'b0, act_h - 1'b1});
    if (cx < 0) col_c = '0;
    else if (cx > w_max) col_c = amt_pkg::COL_W'(w_max);
    else col_c = amt_pkg::COL_W'(cx);
    if (ry < 0) row_c = '0;
    else if (ry > h_max) row_c = amt_pkg::ROW_W'(h_max);
    else row_c = amt_pkg::ROW_W'(ry);
    last_issue = (cx == x_hi) && (ry == y_hi);
  end

  // Frame geometry for the incoming pixel, latched at the first pixel.
  always_comb begin
    frame_start = (in_col == '0) && (in_row == '0);
    w_new   = amt_pkg::fit_dim(cfg.width, amt_pkg::DIM_W'(amt_pkg::MAX_WIDTH));
    h_new   = amt_pkg::fit_dim(cfg.height, amt_pkg::DIM_W'(amt_pkg::MAX_HEIGHT));
    win_new = (cfg.window == '0) ? amt_pkg::WIN_W'(1) :
              ((cfg.window > amt_pkg::WIN_W'(amt_pkg::MAX_WINDOW)) ?
               amt_pkg::WIN_W'(amt_pkg::MAX_WINDOW) : cfg.window);
    w_eff   = frame_start ? w_new : act_w;
    h_eff   = frame_start ? h_new : act_h;
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= amt_pkg::ST_IDLE;
    else state <= state_next;
  end

  // Next state and strobes.
  always_comb begin
    state_next = state;
    item_pop   = 1'b0;
    send_hold  = 1'b0;
    start      = 1'b0;
    unique case (state)
      amt_pkg::ST_IDLE: begin
        if (item_valid) begin
          item_pop   = 1'b1;
          state_next = amt_pkg::ST_CHECK;
        end
      end
      amt_pkg::ST_CHECK: begin
        if (!hold_valid || out_free) begin
          send_hold = hold_valid;
          if (cond) begin
            start      = 1'b1;
            state_next = amt_pkg::ST_SUM;
          end else begin
            state_next = amt_pkg::ST_IDLE;
          end
        end
      end
      amt_pkg::ST_SUM: begin
        if (last_issue) state_next = amt_pkg::ST_WAIT;
      end
      amt_pkg::ST_WAIT: state_next = amt_pkg::ST_MUL;
      amt_pkg::ST_MUL:  state_next = amt_pkg::ST_CMP;
      amt_pkg::ST_CMP:  state_next = amt_pkg::ST_CHECK;
      default:          state_next = amt_pkg::ST_IDLE;
    endcase
  end

  // Ring write for pixels, reads for the centre and then each window pixel.
  assign ram_we    = item_pop && (item.kind == amt_pkg::KIND_PIXEL);
  assign ram_waddr = {in_row[amt_pkg::RING_BITS-1:0], in_col};
  assign ram_re    = start || (state == amt_pkg::ST_SUM);
  assign ram_raddr = start ? {out_row_count[amt_pkg::RING_BITS-1:0], out_col_count}
                           : {row_c[amt_pkg::RING_BITS-1:0], col_c};

  amt_ram #(
    .WIDTH (amt_pkg::PIX_W),
    .DEPTH (amt_pkg::RAM_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (item.pixel),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Datapath registers of the window sequencer.
  always_ff @(posedge clk) begin
    if (start) begin
      ry  <= y_lo;
      cx  <= x_lo;
      acc <= '0;
    end else if (state == amt_pkg::ST_SUM) begin
      if (cx == x_hi) begin
        cx <= x_lo;
        ry <= ry + 1'b1;
      end else begin
        cx <= cx + 1'b1;
      end
    end
    if (rd_ctr_q) centre <= ram_rdata;
    if (rd_sum_q) acc <= acc + amt_pkg::SUM_W'(ram_rdata);
    // The truncated mean exceeds centre plus threshold exactly when the sum reaches this bound.
    if (state == amt_pkg::ST_MUL) begin
      prod <= (amt_pkg::PROD_W'(centre) + amt_pkg::PROD_W'(act_thr) +
               amt_pkg::PROD_W'(1)) * amt_pkg::PROD_W'(act_div);
    end
    if (state == amt_pkg::ST_CMP) begin
      hold_value <= ({2'b00, acc} >= prod) ? amt_pkg::VALUE_SET : amt_pkg::VALUE_CLEAR;
      hold_col   <= out_col_count;
      hold_row   <= out_row_count;
      hold_flast <= pos_last;
    end
    if (send_hold) begin
      out_value      <= hold_value;
      out_col        <= hold_col;
      out_row        <= hold_row;
      out_frame_last <= hold_flast;
      out_run_last   <= !cond;
    end
  end

  // Control state: counters, frame geometry, pending and output flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      act_w         <= amt_pkg::DIM_W'(640);
      act_h         <= amt_pkg::DIM_W'(480);
      act_r         <= amt_pkg::RAD_W'(7);
      act_div       <= amt_pkg::DIV_W'(225);
      act_thr       <= amt_pkg::PIX_W'(7);
      in_col        <= '0;
      in_row        <= '0;
      have_col      <= '0;
      have_row      <= '0;
      out_col_count <= '0;
      out_row_count <= '0;
      busy          <= 1'b0;
      frame_full    <= 1'b0;
      n             <= '0;
      rd_sum_q      <= 1'b0;
      rd_ctr_q      <= 1'b0;
      hold_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      rd_sum_q <= (state == amt_pkg::ST_SUM);
      rd_ctr_q <= start;
      if (item_pop) n <= '0;

      if (ram_we) begin
        if (frame_start) begin
          act_w         <= w_new;
          act_h         <= h_new;
          act_r         <= amt_pkg::RAD_W'(win_new >> 1);
          act_div       <= amt_pkg::DIV_W'(win_new) * amt_pkg::DIV_W'(win_new);
          act_thr       <= cfg.threshold;
          out_col_count <= '0;
          out_row_count <= '0;
          busy          <= 1'b1;
          // A one-pixel frame is complete at once and keeps the flag set below.
          if (!((w_eff == amt_pkg::DIM_W'(1)) && (h_eff == amt_pkg::DIM_W'(1)))) begin
            frame_full <= 1'b0;
          end
        end
        have_col <= in_col;
        have_row <= in_row;
        if ({1'b0, in_col} + 1'b1 == w_eff) begin
          in_col <= '0;
          if ({1'b0, in_row} + 1'b1 == h_eff) begin
            in_row     <= '0;
            frame_full <= 1'b1;
          end else begin
            in_row <= in_row + 1'b1;
          end
        end else begin
          in_col <= in_col + 1'b1;
        end
      end

      // Finished result: park it and step the output position.
      if (state == amt_pkg::ST_CMP) begin
        hold_valid <= 1'b1;
        n          <= n + 1'b1;
        if (pos_last) begin
          busy          <= 1'b0;
          out_col_count <= '0;
          out_row_count <= '0;
        end else if ({1'b0, out_col_count} + 1'b1 == act_w) begin
          out_col_count <= '0;
          out_row_count <= out_row_count + 1'b1;
        end else begin
          out_col_count <= out_col_count + 1'b1;
        end
      end

      if (send_hold) begin
        hold_valid <= 1'b0;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/adaptive_mean_threshold.sv =====
// Top level of the adaptive mean threshold block: configuration registers and streams.
// Depends on amt_pkg, amt_front and amt_back.
`timescale 1ns / 1ps

// Binarizes a raster stream of 8-bit grey pixels against the local mean of a square
// window with replicated edges. Input requests queue in a two-entry front queue, so
// the input side keeps moving while a result waits on the output register. Each
// request is then handled alone: a pixel is stored in a 32-row line ring, after which
// up to 16 ready results are produced. Every result walks its window through the
// single read port of the line ring. Drain requests flush the rows left after the last
// pixel of a frame. Geometry registers are sampled at the first pixel of each frame.

module adaptive_mean_threshold (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // pixel[7:0]
  input  logic                            s_tuser,   // kind
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [amt_pkg::TDATA_W-1:0]     m_tdata,   // out_value[7:0], out_col[18:8],
                                                     // out_row[29:19], zero[31:30]
  output logic                            m_tlast,   // run_last
  output logic                            m_tuser,   // frame_last
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [amt_pkg::IDX_W-1:0]       cfg_index,
  input  logic [amt_pkg::CFG_W-1:0]       cfg_data
);

  amt_pkg::cfg_t  cfg;
  amt_pkg::item_t in_item, item;
  logic           item_valid, item_pop;
  logic [amt_pkg::PIX_W-1:0] out_value;
  logic [amt_pkg::COL_W-1:0] out_col;
  logic [amt_pkg::ROW_W-1:0] out_row;

  assign cfg_ready = 1'b1;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width     <= amt_pkg::DIM_W'(640);
      cfg.height    <= amt_pkg::DIM_W'(480);
      cfg.window    <= amt_pkg::WIN_W'(15);
      cfg.threshold <= amt_pkg::PIX_W'(7);
    end else if (cfg_valid) begin
      case (amt_pkg::reg_idx_t'(cfg_index))
        amt_pkg::REG_WIDTH:     cfg.width     <= cfg_data;
        amt_pkg::REG_HEIGHT:    cfg.height    <= cfg_data;
        amt_pkg::REG_WINDOW:    cfg.window    <= cfg_data[amt_pkg::WIN_W-1:0];
        amt_pkg::REG_THRESHOLD: cfg.threshold <= cfg_data[amt_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_item.kind  = s_tuser;
  assign in_item.pixel = s_tdata;

  amt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  amt_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .item_valid     (item_valid),
    .item           (item),
    .item_pop       (item_pop),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_value      (out_value),
    .out_col        (out_col),
    .out_row        (out_row),
    .out_run_last   (m_tlast),
    .out_frame_last (m_tuser)
  );

  assign m_tdata = {2'b00, out_row, out_col, out_value};

endmodule

// ===== rtl/core/amt_checker.sv =====
// Port-level checker for adaptive_mean_threshold, attached by a bind statement.
// Depends on the top level's ports only.
`timescale 1ns / 1ps

module amt_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  // A stalled result holds its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // Results are binary.
  a_binary: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:0] == 8'd0 || m_tdata[7:0] == 8'd255))
    else $error("result value not binary");

  // The final pixel of a frame always closes its request's run.
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("frame end not marked as run end");

  // Padding bits stay clear.
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[31:30] == 2'b00)
    else $error("padding bits set");

endmodule

bind adaptive_mean_threshold amt_checker u_amt_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
